[hw/rtl/rrb_pkg.sv]
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared constants of the read range bunching block.
// ----------------------------------------------------------------------------
package rrb_pkg;

  localparam int unsigned MaxRangesDefault = 64;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned EndW   = 17;
  localparam int unsigned CountW = 11;
  localparam int unsigned CfgW   = 11;

  localparam logic [1:0] CfgBitMode   = 2'd0;
  localparam logic [1:0] CfgMaxBits   = 2'd1;
  localparam logic [1:0] CfgMaxWords  = 2'd2;
  localparam logic [1:0] CfgMaxDummy  = 2'd3;

  localparam logic KindLoad    = 1'b0;
  localparam logic KindRequest = 1'b1;

endpackage

[hw/rtl/read_range_bunching.sv]
// ----------------------------------------------------------------------------
// read_range_bunching
// Sorts loaded register ranges and hands out merged read bunches on request.
// ----------------------------------------------------------------------------
// channel  | direction | handshake         | payload
// in       | input     | in_valid/in_stall | kind, range_start, range_count, last_range
// out      | output    | out_valid/out_stall | bunch_start, bunch_count, final_bunch, nothing_left
// cfg      | input     | cfg_we            | cfg_index, cfg_data
//
// a load walks the sorted table down one entry at a time (ram read, then shift
// write) until it reaches the insert position; a request steps through fetch,
// first read, absorb read, absorb compare and join while merging table entries.
// the table RAM has a single port, so these steps run one after another.
// reset needs no clearing pass.
// the input is stalled while an item is in work or a result waits on out_stall.
module read_range_bunching
  import rrb_pkg::*;
#(
  parameter int unsigned MaxRanges = MaxRangesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [AddrW-1:0]  range_start_i,
  input  logic [CountW-1:0] range_count_i,
  input  logic              last_range_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [AddrW-1:0]  bunch_start_o,
  output logic [CountW-1:0] bunch_count_o,
  output logic              final_bunch_o,
  output logic              nothing_left_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int unsigned CntW = $clog2(MaxRanges + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxRanges);

  localparam logic [1:0] PhLoading = 2'd0;
  localparam logic [1:0] PhIdle    = 2'd1;
  localparam logic [1:0] PhOpen    = 2'd2;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StInsRd  = 4'd1;
  localparam logic [3:0] StInsCmp = 4'd2;
  localparam logic [3:0] StInsWr  = 4'd3;
  localparam logic [3:0] StReq    = 4'd4;
  localparam logic [3:0] StFirst  = 4'd5;
  localparam logic [3:0] StAbsRd  = 4'd6;
  localparam logic [3:0] StAbs    = 4'd7;
  localparam logic [3:0] StJoin   = 4'd8;
  localparam logic [3:0] StOut    = 4'd9;

  // configuration registers
  logic              bit_mode_q;
  logic [10:0]       max_bits_q;
  logic [6:0]        max_words_q;
  logic [7:0]        max_dummy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_mode_q  <= 1'b0;
      max_bits_q  <= 11'd2000;
      max_words_q <= 7'd125;
      max_dummy_q <= 8'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBitMode:  bit_mode_q  <= cfg_data_i[0];
        CfgMaxBits:  max_bits_q  <= cfg_data_i[10:0];
        CfgMaxWords: max_words_q <= cfg_data_i[6:0];
        CfgMaxDummy: max_dummy_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // derived limits
  logic [10:0] size_lim;
  logic [10:0] max_gap;
  always_comb begin
    size_lim = bit_mode_q ? max_bits_q : {4'd0, max_words_q};
    if (size_lim == '0) begin
      size_lim = 11'd1;
    end
    max_gap = bit_mode_q ? {max_dummy_q, 3'd0} : {4'd0, max_dummy_q[7:1]};
  end

  // state
  logic [3:0]        st_q, st_d;
  logic [1:0]        ph_q, ph_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   cur_q, cur_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [EndW-1:0]   obs_q, obs_d;
  logic [EndW-1:0]   obe_q, obe_d;
  logic [AddrW-1:0]  ns_q, ns_d;
  logic [EndW-1:0]   ne_q, ne_d;
  logic [AddrW-1:0]  ms_q, ms_d;
  logic [EndW-1:0]   me_q, me_d;
  logic              ov_q, ov_d;
  logic [AddrW-1:0]  os_q, os_d;
  logic [CountW-1:0] oc_q, oc_d;
  logic              of_q, of_d;
  logic              on_q, on_d;

  // table RAM, one port, entry = {end, start}
  logic                    ram_we;
  logic [IdxW-1:0]         ram_addr;
  logic [EndW+AddrW-1:0]   ram_wdata;
  logic [EndW+AddrW-1:0]   ram_rdata;
  logic [AddrW-1:0]        rd_s;
  logic [EndW-1:0]         rd_e;

  rrb_ram #(.Width(EndW + AddrW), .Depth(MaxRanges)) u_tab (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );
  assign rd_s = ram_rdata[AddrW-1:0];
  assign rd_e = ram_rdata[EndW+AddrW-1:AddrW];

  logic            in_acc;
  logic [EndW-1:0] new_end;
  logic [EndW-1:0] span;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle) || ov_q;
  assign out_valid_o = ov_q;
  assign bunch_start_o = os_q;
  assign bunch_count_o = oc_q;
  assign final_bunch_o = of_q;
  assign nothing_left_o = on_q;
  assign span = obe_q - obs_q;

  // range end, clamped to the top of the address space
  always_comb begin
    new_end = {1'b0, range_start_i} + {6'd0, range_count_i};
    if (new_end > 17'h10000) begin
      new_end = 17'h10000;
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q; ph_d = ph_q; cnt_d = cnt_q; cur_d = cur_q; pos_d = pos_q;
    obs_d = obs_q; obe_d = obe_q; ns_d = ns_q; ne_d = ne_q; ms_d = ms_q; me_d = me_q;
    ov_d = ov_q; os_d = os_q; oc_d = oc_q; of_d = of_q; on_d = on_q;
    ram_we = 1'b0; ram_addr = '0; ram_wdata = '0;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    unique case (st_q)
      StIdle: begin
        if (in_acc) begin
          if (kind_i == KindLoad) begin
            if (ph_q != PhLoading) begin
              cnt_d = '0; cur_d = '0; ph_d = PhLoading;
            end
            if (last_range_i) begin
              cur_d = '0; ph_d = PhIdle;
            end
            ns_d = range_start_i;
            ne_d = new_end;
            if (range_count_i != '0 && (ph_q != PhLoading || cnt_q < CntMax)) begin
              pos_d = (ph_q != PhLoading) ? '0 : cnt_q;
              cnt_d = ((ph_q != PhLoading) ? '0 : cnt_q) + 1'b1;
              st_d = StInsRd;
            end
          end else if (ph_q == PhLoading) begin
            ov_d = 1'b1; os_d = '0; oc_d = '0; of_d = 1'b0; on_d = 1'b1;
          end else begin
            st_d = StReq;
          end
        end
      end
      // read the entry below the insert position
      StInsRd: begin
        if (pos_q == '0) begin
          st_d = StInsWr;
        end else begin
          ram_addr = IdxW'(pos_q - 1'b1);
          st_d = StInsCmp;
        end
      end
      StInsCmp: begin
        if (rd_s > ns_q) begin
          ram_we = 1'b1;
          ram_addr = IdxW'(pos_q);
          ram_wdata = ram_rdata;
          pos_d = pos_q - 1'b1;
          st_d = StInsRd;
        end else begin
          st_d = StInsWr;
        end
      end
      StInsWr: begin
        ram_we = 1'b1;
        ram_addr = IdxW'(pos_q);
        ram_wdata = {ne_q, ns_q};
        st_d = StIdle;
      end
      // request: split, end of set, or fetch next interval
      StReq: begin
        if (ph_q == PhOpen && span > {6'd0, size_lim}) begin
          os_d = obs_q[AddrW-1:0]; oc_d = size_lim; of_d = 1'b0; on_d = 1'b0;
          obs_d = obs_q + {6'd0, size_lim};
          st_d = StOut;
        end else if (cur_q >= cnt_q) begin
          if (ph_q == PhOpen) begin
            os_d = obs_q[AddrW-1:0]; oc_d = span[CountW-1:0]; of_d = 1'b1; on_d = 1'b0;
            ph_d = PhIdle;
          end else begin
            os_d = '0; oc_d = '0; of_d = 1'b0; on_d = 1'b1;
          end
          st_d = StOut;
        end else begin
          ram_addr = IdxW'(cur_q);
          cur_d = cur_q + 1'b1;
          st_d = StFirst;
        end
      end
      StFirst: begin
        ms_d = rd_s; me_d = rd_e;
        st_d = StAbsRd;
      end
      StAbsRd: begin
        if (cur_q >= cnt_q) begin
          st_d = StJoin;
        end else begin
          ram_addr = IdxW'(cur_q);
          st_d = StAbs;
        end
      end
      StAbs: begin
        if ({1'b0, rd_s} <= me_q) begin
          if (rd_e > me_q) begin
            me_d = rd_e;
          end
          cur_d = cur_q + 1'b1;
          st_d = StAbsRd;
        end else begin
          st_d = StJoin;
        end
      end
      StJoin: begin
        if (ph_q != PhOpen) begin
          obs_d = {1'b0, ms_q}; obe_d = me_q; ph_d = PhOpen;
          st_d = StReq;
        end else if (({1'b0, ms_q} - obe_q) <= {6'd0, max_gap}
                     && (me_q - obs_q) <= {6'd0, size_lim}) begin
          obe_d = me_q;
          st_d = StReq;
        end else begin
          os_d = obs_q[AddrW-1:0]; oc_d = span[CountW-1:0]; of_d = 1'b0; on_d = 1'b0;
          obs_d = {1'b0, ms_q}; obe_d = me_q;
          st_d = StOut;
        end
      end
      StOut: begin
        ov_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ph_q <= PhLoading; cnt_q <= '0; cur_q <= '0;
      obs_q <= '0; obe_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; cnt_q <= cnt_d; cur_q <= cur_d;
      obs_q <= obs_d; obe_q <= obe_d; ov_q <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; ns_q <= ns_d; ne_q <= ne_d; ms_q <= ms_d; me_q <= me_d;
    os_q <= os_d; oc_q <= oc_d; of_q <= of_d; on_q <= on_d;
  end

endmodule

[hw/rtl/rrb_ram.sv]
// ----------------------------------------------------------------------------
// rrb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                             wdata_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
